FILE: rtl/wnpip_pkg.sv
// Shared types and constants for the winding-number point-in-polygon block.
// No dependencies; imported by every other file in rtl/.
`timescale 1ns / 1ps

package wnpip_pkg;

  localparam int NORM_W    = 18;
  localparam int OP_W      = 2;
  localparam int WIND_W    = 8;
  localparam int VCNT_W    = 7;
  localparam int CFG_IDX_W = 2;

  // cycles spent after the last rotation step so the edge pipeline drains
  localparam int DRAIN_CYC = 4;
  localparam int DRAIN_W   = 2;

  localparam int WIND_MAX = 127;
  localparam int WIND_MIN = -128;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 2'd2;

  localparam logic signed [NORM_W-1:0] NORMAL_Z_RST = 18'sd65536;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROT   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  // per-cell control: load a new vertex, or take the neighbor's vertex
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // edge unit control: edge present this cycle, clear the accumulator
  typedef struct packed {
    logic vld;
    logic clr;
  } edge_ctl_t;

  // unsigned magnitude of a normal component; most negative code maps to 2^17
  function automatic logic [NORM_W-1:0] norm_mag(input logic signed [NORM_W-1:0] n);
    logic [NORM_W-1:0] m;
    m = n[NORM_W-1] ? (~n + 1'b1) : n;
    return m;
  endfunction

endpackage

FILE: rtl/wnpip_cell.sv
// One storage cell of the vertex chain: holds a projected (u, v) pair.
// Loads a vertex on append, or takes its neighbor's pair while rotating.
// Depends on wnpip_pkg.
`timescale 1ns / 1ps

module wnpip_cell #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  wnpip_pkg::cell_ctl_t         ctl,
  input  logic signed [COORD_BITS-1:0] ld_u,
  input  logic signed [COORD_BITS-1:0] ld_v,
  input  logic signed [COORD_BITS-1:0] nb_u,
  input  logic signed [COORD_BITS-1:0] nb_v,
  output logic signed [COORD_BITS-1:0] u,
  output logic signed [COORD_BITS-1:0] v
);

  logic signed [COORD_BITS-1:0] u_r;
  logic signed [COORD_BITS-1:0] v_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      u_r <= ld_u;
      v_r <= ld_v;
    end else if (ctl.shift) begin
      u_r <= nb_u;
      v_r <= nb_v;
    end
  end

  assign u = u_r;
  assign v = v_r;

endmodule

FILE: rtl/wnpip_edge.sv
// Edge evaluation pipeline: crossing test of one polygon edge per cycle
// against the query point, exact cross-product sign, winding accumulator.
// Depends on wnpip_pkg.
`timescale 1ns / 1ps

module wnpip_edge #(
  parameter int COORD_BITS = 24,
  parameter int WN_W       = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wnpip_pkg::edge_ctl_t         ctl,
  input  logic signed [COORD_BITS-1:0] pu,
  input  logic signed [COORD_BITS-1:0] pv,
  input  logic signed [COORD_BITS-1:0] u1,
  input  logic signed [COORD_BITS-1:0] v1,
  input  logic signed [COORD_BITS-1:0] u2,
  input  logic signed [COORD_BITS-1:0] v2,
  output logic signed [WN_W-1:0]       wn
);

  localparam int D_W = COORD_BITS + 1;
  localparam int P_W = 2 * D_W;

  // stage A: edge endpoints
  logic                         a_vld_r;
  logic signed [COORD_BITS-1:0] a_u1_r, a_v1_r, a_u2_r, a_v2_r;
  // stage B: differences and crossing direction
  logic                         b_vld_r, b_up_r, b_dn_r;
  logic signed [D_W-1:0]        b_du_r, b_dpv_r, b_dpu_r, b_dv_r;
  // stage C: the two cross-product terms
  logic                         c_vld_r, c_up_r, c_dn_r;
  logic signed [P_W-1:0]        c_lhs_r, c_rhs_r;
  logic signed [WN_W-1:0]       acc_r;
  logic signed [WN_W-1:0]       acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= ctl.vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_u1_r  <= u1;
    a_v1_r  <= v1;
    a_u2_r  <= u2;
    a_v2_r  <= v2;

    b_up_r  <= (a_v1_r <= pv) && (a_v2_r > pv);
    b_dn_r  <= (a_v1_r > pv) && (a_v2_r <= pv);
    b_du_r  <= D_W'(a_u2_r) - D_W'(a_u1_r);
    b_dpv_r <= D_W'(pv) - D_W'(a_v1_r);
    b_dpu_r <= D_W'(pu) - D_W'(a_u1_r);
    b_dv_r  <= D_W'(a_v2_r) - D_W'(a_v1_r);

    c_up_r  <= b_up_r;
    c_dn_r  <= b_dn_r;
    c_lhs_r <= P_W'(b_du_r) * P_W'(b_dpv_r);
    c_rhs_r <= P_W'(b_dpu_r) * P_W'(b_dv_r);
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (c_vld_r) begin
      if (c_up_r && (c_lhs_r > c_rhs_r)) begin
        acc_nxt = acc_r + WN_W'(1);
      end else if (c_dn_r && (c_lhs_r < c_rhs_r)) begin
        acc_nxt = acc_r - WN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign wn = acc_r;

endmodule

FILE: rtl/winding_number_point_in_polygon.sv
// Top level of the winding-number point-in-polygon block.
// Instantiates the vertex cell chain (wnpip_cell) and the edge pipeline
// (wnpip_edge); depends on wnpip_pkg.
//
// Usage:
//   Requests arrive on start/in_op/in_coord_*; one is taken at a clock edge
//   with start high and busy low. Op clear empties the vertex store, append
//   projects the vertex (drops the axis of the largest normal magnitude) and
//   stores it, query returns the winding number of the projected point.
//   Each clear/append/query gives one result on out_* for one cycle, marked
//   by out_valid; op code 3 is dropped with no result.
//   Clear and append: result the cycle after the request, busy stays low, so
//   one of these can be taken every cycle.
//   Query: the vertex chain rotates once through all MAX_VERTICES cells, one
//   edge per cycle into the edge pipeline, then the pipeline drains;
//   the result follows, with busy high throughout.
//   Normal registers are written on cfg_* (always ready); write only while
//   idle. Synchronous reset empties the store, clears the overflow flag and
//   loads the normal (0, 0, 1.0). Results cannot be held off: out_valid is a
//   single-cycle strobe and the receiver must take it.
`timescale 1ns / 1ps

module winding_number_point_in_polygon #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 24
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  output logic                                        busy,
  input  logic [wnpip_pkg::OP_W-1:0]                  in_op,
  input  logic signed [COORD_BITS-1:0]                in_coord_x,
  input  logic signed [COORD_BITS-1:0]                in_coord_y,
  input  logic signed [COORD_BITS-1:0]                in_coord_z,
  output logic                                        out_valid,
  output logic signed [wnpip_pkg::WIND_W-1:0]         out_winding,
  output logic                                        out_inside_res,
  output logic [wnpip_pkg::VCNT_W-1:0]                out_vertex_count,
  output logic                                        out_overflow,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [wnpip_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic signed [wnpip_pkg::NORM_W-1:0]         cfg_data
);

  import wnpip_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int WN_W  = CNT_W + 1;

  state_t                       state_r, state_nxt;
  logic [IDX_W-1:0]             step_r, step_nxt;
  logic [DRAIN_W-1:0]           drain_r, drain_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         ovf_r, ovf_nxt;
  logic signed [COORD_BITS-1:0] pu_r, pv_r, first_u_r, first_v_r;
  logic signed [NORM_W-1:0]     nx_r, ny_r, nz_r;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [WIND_W-1:0]     wind_r, wind_nxt;
  logic                         inside_r, inside_nxt;
  logic [VCNT_W-1:0]            vcnt_r, vcnt_nxt;
  logic                         oflag_r, oflag_nxt;

  logic                         accept, full, rotating, do_append, do_query;
  logic [NORM_W-1:0]            mag_x, mag_y, mag_z, mag_xy;
  logic                         drop_y, drop_z;
  logic signed [COORD_BITS-1:0] proj_u, proj_v;

  logic signed [COORD_BITS-1:0] cell_u [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] cell_v [MAX_VERTICES];

  edge_ctl_t                    ectl;
  logic [CNT_W-1:0]             step_ext;
  logic                         last_edge;
  logic signed [COORD_BITS-1:0] e_u2, e_v2;
  logic signed [WN_W-1:0]       wn;
  int                           wn_int;
  logic signed [WIND_W-1:0]     wn_sat;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign full      = (count_r == CNT_W'(MAX_VERTICES));
  assign rotating  = (state_r == ST_ROT);
  assign do_append = accept && (in_op == OP_APPEND);
  assign do_query  = accept && (in_op == OP_QUERY);
  assign cfg_ready = 1'b1;

  // projection: drop axis of largest |normal|, first axis wins ties
  assign mag_x  = norm_mag(nx_r);
  assign mag_y  = norm_mag(ny_r);
  assign mag_z  = norm_mag(nz_r);
  assign drop_y = (mag_y > mag_x);
  assign mag_xy = drop_y ? mag_y : mag_x;
  assign drop_z = (mag_z > mag_xy);
  assign proj_u = (drop_y || drop_z) ? in_coord_x : in_coord_y;
  assign proj_v = drop_z ? in_coord_y : in_coord_z;

  // vertex chain; rotation moves cell k+1 into cell k, wrapping at the end
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    cell_ctl_t cctl;
    assign cctl.load  = do_append && !full && (count_r == CNT_W'(k));
    assign cctl.shift = rotating;

    wnpip_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk  (clk),
      .ctl  (cctl),
      .ld_u (proj_u),
      .ld_v (proj_v),
      .nb_u (cell_u[(k + 1) % MAX_VERTICES]),
      .nb_v (cell_v[(k + 1) % MAX_VERTICES]),
      .u    (cell_u[k]),
      .v    (cell_v[k])
    );
  end

  // at step t cell 0 holds vertex t; the closing edge goes back to vertex 0
  assign step_ext  = CNT_W'(step_r);
  assign last_edge = ((step_ext + CNT_W'(1)) == count_r);
  assign e_u2      = last_edge ? first_u_r : cell_u[1];
  assign e_v2      = last_edge ? first_v_r : cell_v[1];
  assign ectl.vld  = rotating && (step_ext < count_r);
  assign ectl.clr  = do_query;

  wnpip_edge #(
    .COORD_BITS(COORD_BITS),
    .WN_W      (WN_W)
  ) u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ectl),
    .pu    (pu_r),
    .pv    (pv_r),
    .u1    (cell_u[0]),
    .v1    (cell_v[0]),
    .u2    (e_u2),
    .v2    (e_v2),
    .wn    (wn)
  );

  always_comb begin
    wn_int = int'(wn);
    if (wn_int > WIND_MAX) begin
      wn_sat = WIND_W'(WIND_MAX);
    end else if (wn_int < WIND_MIN) begin
      wn_sat = WIND_W'(WIND_MIN);
    end else begin
      wn_sat = WIND_W'(wn_int);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    drain_nxt     = drain_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    wind_nxt      = wind_r;
    inside_nxt    = inside_r;
    vcnt_nxt      = vcnt_r;
    oflag_nxt     = oflag_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              wind_nxt      = '0;
              inside_nxt    = 1'b0;
              vcnt_nxt      = '0;
              oflag_nxt     = ovf_r;
            end
            OP_APPEND: begin
              if (full) begin
                ovf_nxt = 1'b1;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
              out_valid_nxt = 1'b1;
              wind_nxt      = '0;
              inside_nxt    = 1'b0;
              vcnt_nxt      = VCNT_W'(count_nxt);
              oflag_nxt     = ovf_nxt;
            end
            OP_QUERY: begin
              step_nxt  = '0;
              state_nxt = ST_ROT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROT: begin
        step_nxt = step_r + IDX_W'(1);
        if (step_r == IDX_W'(MAX_VERTICES - 1)) begin
          drain_nxt = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + DRAIN_W'(1);
        if (drain_r == DRAIN_W'(DRAIN_CYC - 1)) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          wind_nxt      = wn_sat;
          inside_nxt    = (wn != '0);
          vcnt_nxt      = VCNT_W'(count_r);
          oflag_nxt     = ovf_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      drain_r     <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      wind_r      <= '0;
      inside_r    <= 1'b0;
      vcnt_r      <= '0;
      oflag_r     <= 1'b0;
      nx_r        <= '0;
      ny_r        <= '0;
      nz_r        <= NORMAL_Z_RST;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      drain_r     <= drain_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      wind_r      <= wind_nxt;
      inside_r    <= inside_nxt;
      vcnt_r      <= vcnt_nxt;
      oflag_r     <= oflag_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NORMAL_X: nx_r <= cfg_data;
          CFG_NORMAL_Y: ny_r <= cfg_data;
          CFG_NORMAL_Z: nz_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // query point and vertex 0 are latched when the query request is taken
  always_ff @(posedge clk) begin
    if (do_query) begin
      pu_r      <= proj_u;
      pv_r      <= proj_v;
      first_u_r <= cell_u[0];
      first_v_r <= cell_v[0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_winding      = wind_r;
  assign out_inside_res   = inside_r;
  assign out_vertex_count = vcnt_r;
  assign out_overflow     = oflag_r;

endmodule

FILE: rtl/wnpip_checker.sv
// Port-level checks for winding_number_point_in_polygon, bound to the top.
// Depends on wnpip_pkg.
`timescale 1ns / 1ps

module wnpip_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [wnpip_pkg::OP_W-1:0]          in_op,
  input logic                                out_valid,
  input logic signed [wnpip_pkg::WIND_W-1:0] out_winding,
  input logic                                out_inside_res,
  input logic [wnpip_pkg::VCNT_W-1:0]        out_vertex_count,
  input logic                                out_overflow
);

  import wnpip_pkg::*;

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_CLEAR) |=>
      (out_valid && out_vertex_count == '0 && out_winding == '0))
    else $error("clear request did not report an empty store");

  a_inside_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_inside_res == (out_winding != '0)))
    else $error("inside flag disagrees with winding number");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_QUERY) |=> (busy && !out_valid))
    else $error("query request did not hold busy");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(out_overflow)) |-> out_overflow)
    else $error("overflow flag dropped without reset");

endmodule

bind winding_number_point_in_polygon wnpip_checker u_wnpip_checker (.*);
